FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, sampled on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define FSTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define FSTS_ASSERT_NEXT(name, pre, post, msg) \
  `FSTS_ASSERT(name, (pre) |=> (post), msg)

`endif

FILE: rtl/fsts_pkg.sv
// ---------------------------------------------------------------------------
// fsts_pkg
// Types, register indexes and constants of the fixed timestep step scheduler.
// ---------------------------------------------------------------------------
package fsts_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BACKLOG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE       = 3'd4;

  localparam int unsigned PERIOD_W    = 25;
  localparam int unsigned STEPS_W     = 11;
  localparam int unsigned SCALE_W     = 16;
  localparam int unsigned DELTA_W     = 32;
  localparam int unsigned OUT_W       = 32;
  localparam int unsigned ALPHA_W     = 17;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned SCALE_SHIFT = 8;
  localparam int unsigned PROD_W      = DELTA_W + SCALE_W;
  localparam int unsigned SIM_W       = STEPS_W + PERIOD_W;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 25'd16777216;
  localparam logic [STEPS_W-1:0]  STEPS_MAX  = 11'd1024;
  localparam logic [ALPHA_W-1:0]  ALPHA_ONE  = 17'd65536;

  localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD = 25'd279620;
  localparam logic [STEPS_W-1:0]  RST_MAX_STEPS   = 11'd8;
  localparam logic [SCALE_W-1:0]  RST_TIME_SCALE  = 16'd256;
  localparam logic [OUT_W-1:0]    RST_MAX_BACKLOG = 32'd4194304;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [DELTA_W-1:0] real_delta;
  } fsts_in_t;

  typedef struct packed {
    logic [STEPS_W-1:0] steps;
    logic [OUT_W-1:0]   dropped_time;
    logic [OUT_W-1:0]   accum_after;
    logic [ALPHA_W-1:0] interp_alpha;
  } fsts_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic mul;
    logic sum;
    logic clamp;
    logic div_step;
    logic sim;
    logic upd;
    logic a_init;
    logic out_load;
  } fsts_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic active;
  } fsts_sts_t;

  function automatic logic [OUT_W-1:0] sat_out(logic [63:0] v);
    logic [OUT_W-1:0] r;
    if (v > 64'h0000_0000_FFFF_FFFF) begin
      r = '1;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/fsts_ctrl.sv
// ---------------------------------------------------------------------------
// fsts_ctrl
// Sequencer of the step scheduler: walks one item through the datapath.
// ---------------------------------------------------------------------------
module fsts_ctrl import fsts_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output fsts_cmd_t cmd_o,
  input  fsts_sts_t sts_i
);

  localparam int unsigned CNT_W = $clog2(TIME_WIDTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_SUM   = 4'd2;
  localparam logic [3:0] S_CLAMP = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_SIM   = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_AINIT = 4'd7;
  localparam logic [3:0] S_ADIV  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             oval_q, oval_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = sts_i.active ? S_SUM : S_UPD;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_CLAMP;
      end
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        cnt_d       = CNT_W'(TIME_WIDTH - 1);
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_SIM;
        end
      end
      S_SIM: begin
        cmd_o.sim = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_AINIT;
      end
      S_AINIT: begin
        cmd_o.a_init = 1'b1;
        cnt_d        = CNT_W'(FRAC_W - 1);
        state_d      = S_ADIV;
      end
      S_ADIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!oval_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    oval_d = oval_q;
    if (cmd_o.out_load) begin
      oval_d = 1'b1;
    end else if (!out_stall_i) begin
      oval_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = oval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      oval_q  <= oval_d;
    end
  end

endmodule

FILE: rtl/fsts_dp.sv
// ---------------------------------------------------------------------------
// fsts_dp
// Datapath: set-up registers, accumulator, multipliers and shared serial divider.
// ---------------------------------------------------------------------------
module fsts_dp import fsts_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fsts_in_t              in_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  fsts_cmd_t             cmd_i,
  output fsts_sts_t             sts_o,
  output fsts_out_t             out_data_o
);

  localparam int unsigned TW       = TIME_WIDTH;
  localparam int unsigned SCALED_W = PROD_W - SCALE_SHIFT;
  localparam int unsigned SW       = ((TW > SCALED_W) ? TW : SCALED_W) + 1;
  localparam logic [63:0] TIME_MAX64 = (64'd1 << TIME_WIDTH) - 64'd1;

  // Set-up registers
  logic [PERIOD_W-1:0] sp_q, sp_d;
  logic [STEPS_W-1:0]  ms_q, ms_d;
  logic [SCALE_W-1:0]  sc_q, sc_d;
  logic [OUT_W-1:0]    bl_q, bl_d;
  logic                pause_q, pause_d;
  logic [TW-1:0]       acc_q, acc_d;

  // Item working registers
  logic                cmd_q, cmd_d;
  logic [DELTA_W-1:0]  delta_q, delta_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [SW-1:0]       sum_q, sum_d;
  logic [TW-1:0]       work_q, work_d;
  logic [SW-1:0]       over_q, over_d;
  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [TW-1:0]       quo_q, quo_d;
  logic [STEPS_W-1:0]  stp_q, stp_d;
  logic                capped_q, capped_d;
  logic [SIM_W-1:0]    sim_q, sim_d;
  logic [SW-1:0]       drop_q, drop_d;
  logic                full_q, full_d;
  fsts_out_t           out_q, out_d;

  logic                wr_sp, wr_bl;
  logic [PERIOD_W-1:0] sp_wr, sp_new;
  logic [STEPS_W-1:0]  ms_wr;
  logic [OUT_W-1:0]    bl_wr, bl_new;
  logic [TW-1:0]       ceil_cur, ceil_new;
  logic                active;
  logic [PERIOD_W:0]   rem_sh;
  logic                div_ge;
  logic [STEPS_W-1:0]  stp_sel;
  logic                cap_sel;
  logic [63:0]         acc_ext;

  function automatic logic [TW-1:0] ceil_of(logic [OUT_W-1:0] bl, logic [PERIOD_W-1:0] sp);
    logic [OUT_W-1:0] mx;
    logic [63:0]      wide;
    mx   = (bl > OUT_W'(sp)) ? bl : OUT_W'(sp);
    wide = (64'(mx) > TIME_MAX64) ? TIME_MAX64 : 64'(mx);
    return wide[TW-1:0];
  endfunction

  // Clamp register writes to their legal ranges
  assign wr_sp  = cfg_we_i && (cfg_idx_i == REG_STEP_PERIOD);
  assign wr_bl  = cfg_we_i && (cfg_idx_i == REG_MAX_BACKLOG);
  assign sp_wr  = (cfg_data_i[PERIOD_W-1:0] == '0) ? PERIOD_W'(1) :
                  (cfg_data_i[PERIOD_W-1:0] > PERIOD_MAX) ? PERIOD_MAX :
                  cfg_data_i[PERIOD_W-1:0];
  assign ms_wr  = (cfg_data_i[STEPS_W-1:0] == '0) ? STEPS_W'(1) :
                  (cfg_data_i[STEPS_W-1:0] > STEPS_MAX) ? STEPS_MAX :
                  cfg_data_i[STEPS_W-1:0];
  assign bl_wr  = (cfg_data_i[OUT_W-1:0] == '0) ? OUT_W'(1) : cfg_data_i[OUT_W-1:0];
  assign sp_new = wr_sp ? sp_wr : sp_q;
  assign bl_new = wr_bl ? bl_wr : bl_q;

  assign ceil_cur = ceil_of(bl_q, sp_q);
  assign ceil_new = ceil_of(bl_new, sp_new);

  assign active = (cmd_q == CMD_FRAME) && !pause_q && (delta_q != '0) && (sc_q != '0);
  assign sts_o.active = active;

  // One restoring division step
  assign rem_sh = {rem_q, quo_q[TW-1]};
  assign div_ge = (rem_sh >= {1'b0, sp_q});

  assign cap_sel = (64'(quo_q) > 64'(ms_q));
  assign stp_sel = cap_sel ? ms_q : quo_q[STEPS_W-1:0];
  assign acc_ext = 64'(acc_q);

  always_comb begin
    sp_d     = sp_q;
    ms_d     = ms_q;
    sc_d     = sc_q;
    bl_d     = bl_q;
    pause_d  = pause_q;
    acc_d    = acc_q;
    cmd_d    = cmd_q;
    delta_d  = delta_q;
    prod_d   = prod_q;
    sum_d    = sum_q;
    work_d   = work_q;
    over_d   = over_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    stp_d    = stp_q;
    capped_d = capped_q;
    sim_d    = sim_q;
    drop_d   = drop_q;
    full_d   = full_q;
    out_d    = out_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STEP_PERIOD: sp_d    = sp_wr;
        REG_MAX_STEPS:   ms_d    = ms_wr;
        REG_TIME_SCALE:  sc_d    = cfg_data_i[SCALE_W-1:0];
        REG_MAX_BACKLOG: bl_d    = bl_wr;
        REG_PAUSE:       pause_d = cfg_data_i[0];
        default: begin
        end
      endcase
      // A new ceiling may sit below the stored backlog
      if ((wr_sp || wr_bl) && (acc_q > ceil_new)) begin
        acc_d = ceil_new;
      end
    end

    if (cmd_i.load_in) begin
      cmd_d   = in_data_i.cmd;
      delta_d = in_data_i.real_delta;
    end

    if (cmd_i.mul) begin
      prod_d = PROD_W'(delta_q) * PROD_W'(sc_q);
    end

    if (cmd_i.sum) begin
      sum_d = SW'(acc_q) + SW'(prod_q[PROD_W-1:SCALE_SHIFT]);
    end

    // Clamp to the ceiling and start the step count division
    if (cmd_i.clamp) begin
      if (sum_q > SW'(ceil_cur)) begin
        work_d = ceil_cur;
        over_d = sum_q - SW'(ceil_cur);
        quo_d  = ceil_cur;
      end else begin
        work_d = sum_q[TW-1:0];
        over_d = '0;
        quo_d  = sum_q[TW-1:0];
      end
      rem_d = '0;
    end

    if (cmd_i.div_step) begin
      rem_d = div_ge ? PERIOD_W'(rem_sh - {1'b0, sp_q}) : rem_sh[PERIOD_W-1:0];
      quo_d = {quo_q[TW-2:0], div_ge};
    end

    if (cmd_i.sim) begin
      stp_d    = stp_sel;
      capped_d = cap_sel;
      sim_d    = SIM_W'(stp_sel) * SIM_W'(sp_q);
    end

    if (cmd_i.upd) begin
      if (active) begin
        if (capped_q) begin
          acc_d  = '0;
          drop_d = sum_q - SW'(sim_q);
        end else begin
          acc_d  = TW'(SW'(work_q) - SW'(sim_q));
          drop_d = over_q;
        end
      end else begin
        stp_d  = '0;
        drop_d = '0;
        if (cmd_q == CMD_CLEAR) begin
          acc_d = '0;
        end
      end
    end

    // Alpha saturates at one once a whole step is banked
    if (cmd_i.a_init) begin
      full_d = (acc_ext >= 64'(sp_q));
      rem_d  = (acc_ext >= 64'(sp_q)) ? '0 : acc_ext[PERIOD_W-1:0];
      quo_d  = '0;
    end

    if (cmd_i.out_load) begin
      out_d.steps        = stp_q;
      out_d.dropped_time = sat_out(64'(drop_q));
      out_d.accum_after  = sat_out(acc_ext);
      out_d.interp_alpha = full_q ? ALPHA_ONE : {1'b0, quo_q[FRAC_W-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q    <= RST_STEP_PERIOD;
      ms_q    <= RST_MAX_STEPS;
      sc_q    <= RST_TIME_SCALE;
      bl_q    <= RST_MAX_BACKLOG;
      pause_q <= 1'b0;
      acc_q   <= '0;
    end else begin
      sp_q    <= sp_d;
      ms_q    <= ms_d;
      sc_q    <= sc_d;
      bl_q    <= bl_d;
      pause_q <= pause_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    delta_q  <= delta_d;
    prod_q   <= prod_d;
    sum_q    <= sum_d;
    work_q   <= work_d;
    over_q   <= over_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    stp_q    <= stp_d;
    capped_q <= capped_d;
    sim_q    <= sim_d;
    drop_q   <= drop_d;
    full_q   <= full_d;
    out_q    <= out_d;
  end

  assign out_data_o = out_q;

endmodule

FILE: rtl/fixed_timestep_step_scheduler.sv
// ---------------------------------------------------------------------------
// fixed_timestep_step_scheduler
// Fixed timestep accumulator: turns frame time into a count of physics steps.
// ---------------------------------------------------------------------------
// One item is worked at a time. A frame that adds time runs the single
// serial restoring divider, one quotient bit per cycle: TIME_WIDTH steps for
// the step count, then 16 steps for the UQ1.16 interpolation alpha. A clear
// item or a frame that adds no time (paused, zero scale, zero delta) runs
// only the alpha division. A finished result sits in an output register, so
// the next item is taken while it waits. Time is in 2^-24 s units; the set-up
// registers are clamped as they are written, and a write to step_period or
// max_backlog pulls the accumulator down to the new ceiling at once. Write the
// registers only while no item is in flight.
`include "assert_macros.svh"

module fixed_timestep_step_scheduler import fsts_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Item input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  fsts_in_t              in_data_i,
  // Result output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output fsts_out_t             out_data_o,
  // Set-up write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  fsts_cmd_t cmd;
  fsts_sts_t sts;

  // Sequencer: one state per datapath phase, with a shared iteration counter
  fsts_ctrl #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath: registers, accumulator, multipliers and the divider
  fsts_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // Hold off further input once a beat has been taken
  `FSTS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input not held off after a beat")

  // Never overwrite a result that is still waiting
  `FSTS_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_o || !out_stall_i), "pending result overwritten")

  // Results stay within the step cap and unit alpha
  `FSTS_ASSERT(a_out_range, out_valid_o |-> (out_data_o.steps <= STEPS_MAX && out_data_o.interp_alpha <= ALPHA_ONE), "result out of range")

  // A loaded result shows as valid in the next cycle
  `FSTS_ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid_o, "loaded result not presented")

endmodule
